[src/c65x_pkg.sv]
// ----------------------------------------------------------------------------
// c65x_pkg: shared types and constants of the 6502-class execute unit
// Operation codes, the architectural register set and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package c65x_pkg;

   typedef enum logic [5:0] {
      K_ADC, K_SBC, K_AND, K_ORA, K_EOR, K_CMP, K_CPX, K_CPY,
      K_BIT, K_LDA, K_LDX, K_LDY, K_LAX,
      K_ASL_A, K_LSR_A, K_ROL_A, K_ROR_A,
      K_ASL_M, K_LSR_M, K_ROL_M, K_ROR_M, K_INC_M, K_DEC_M,
      K_SLO, K_RLA, K_SRE, K_RRA, K_DCP, K_ISB,
      K_STA, K_STX, K_STY, K_SAX,
      K_TAX, K_TAY, K_TSX, K_TXA, K_TXS, K_TYA,
      K_INX, K_INY, K_DEX, K_DEY,
      K_CLC, K_SEC, K_CLI, K_SEI, K_CLV, K_CLD, K_SED,
      K_PHA, K_PHP, K_PLA, K_PLP,
      K_BCC, K_BCS, K_BEQ, K_BMI, K_BNE, K_BPL, K_BVC, K_BVS,
      K_NOP, K_NOP_ALT
   } kind_type;

   localparam logic [2:0] FLAG_C = 3'd0;
   localparam logic [2:0] FLAG_Z = 3'd1;
   localparam logic [2:0] FLAG_I = 3'd2;
   localparam logic [2:0] FLAG_D = 3'd3;
   localparam logic [2:0] FLAG_U = 3'd5;
   localparam logic [2:0] FLAG_V = 3'd6;
   localparam logic [2:0] FLAG_N = 3'd7;

   localparam logic [7:0] FLAGS_RESET = 8'h24;
   localparam logic [7:0] SP_RESET    = 8'hFD;
   localparam logic [7:0] PUSH_BITS   = 8'b0011_0000;
   localparam logic [7:0] UNUSED_BIT  = 8'h20;
   localparam logic [8:0] STACK_BASE  = 9'h100;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] p;
      logic [7:0] sp;
   } regs_type;

   typedef struct packed {
      logic [7:0] result_byte;
      logic       write_back;
      logic       stack_access;
      logic [8:0] stack_address;
      logic       branch_taken;
   } rsp_type;

endpackage

`default_nettype wire

[src/c65x_alu.sv]
// ----------------------------------------------------------------------------
// c65x_alu: single-pass execute logic
// Computes the next register set and the result record for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module c65x_alu
   import c65x_pkg::*;
(
   input  var kind_type   kind,
   input  var logic [7:0] operand,
   input  var regs_type   regs_cur,
   output var regs_type   regs_next,
   output var rsp_type    rsp_next
);

   typedef enum logic [1:0] {SH_ASL, SH_LSR, SH_ROL, SH_ROR} shift_kind_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] p;
   } alu_out_type;

   function automatic logic [7:0] nz_flags(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] q;
      q         = p;
      q[FLAG_Z] = (v == 8'h00);
      q[FLAG_N] = v[7];
      return q;
   endfunction

   function automatic alu_out_type add_op(input logic [7:0] a, input logic [7:0] v,
                                          input logic [7:0] p);
      logic [8:0]  s;
      alu_out_type o;
      s         = {1'b0, a} + {1'b0, v} + {8'h00, p[FLAG_C]};
      o.r       = s[7:0];
      o.p       = nz_flags(p, s[7:0]);
      o.p[FLAG_C] = s[8];
      o.p[FLAG_V] = (a[7] ^ s[7]) & (v[7] ^ s[7]);
      return o;
   endfunction

   function automatic logic [7:0] cmp_op(input logic [7:0] reg_v, input logic [7:0] v,
                                         input logic [7:0] p);
      logic [7:0] q;
      q         = nz_flags(p, reg_v - v);
      q[FLAG_C] = (reg_v >= v);
      return q;
   endfunction

   function automatic alu_out_type shift_op(input shift_kind_type sk, input logic [7:0] v,
                                            input logic [7:0] p);
      alu_out_type o;
      o.p = p;
      unique case (sk)
         SH_ASL: begin
            o.r = {v[6:0], 1'b0};
            o.p[FLAG_C] = v[7];
         end
         SH_LSR: begin
            o.r = {1'b0, v[7:1]};
            o.p[FLAG_C] = v[0];
         end
         SH_ROL: begin
            o.r = {v[6:0], p[FLAG_C]};
            o.p[FLAG_C] = v[7];
         end
         SH_ROR: begin
            o.r = {p[FLAG_C], v[7:1]};
            o.p[FLAG_C] = v[0];
         end
         default: begin
            o.r = v;
         end
      endcase
      o.p = nz_flags(o.p, o.r);
      return o;
   endfunction

   regs_type    r;
   alu_out_type t;
   logic [7:0]  m;
   logic        wb;
   logic        stk;
   logic        br;
   logic [8:0]  saddr;

   always_comb begin
      r     = regs_cur;
      t     = '0;
      m     = 8'h00;
      wb    = 1'b0;
      stk   = 1'b0;
      br    = 1'b0;
      saddr = STACK_BASE;
      unique case (kind)
         K_ADC: begin
            t = add_op(r.a, operand, r.p);
            r.a = t.r;
            r.p = t.p;
         end
         K_SBC: begin
            t = add_op(r.a, ~operand, r.p);
            r.a = t.r;
            r.p = t.p;
         end
         K_AND: begin
            r.a = r.a & operand;
            r.p = nz_flags(r.p, r.a);
         end
         K_ORA: begin
            r.a = r.a | operand;
            r.p = nz_flags(r.p, r.a);
         end
         K_EOR: begin
            r.a = r.a ^ operand;
            r.p = nz_flags(r.p, r.a);
         end
         K_CMP: r.p = cmp_op(r.a, operand, r.p);
         K_CPX: r.p = cmp_op(r.x, operand, r.p);
         K_CPY: r.p = cmp_op(r.y, operand, r.p);
         K_BIT: begin
            r.p[FLAG_N] = operand[7];
            r.p[FLAG_V] = operand[6];
            r.p[FLAG_Z] = ((operand & r.a) == 8'h00);
            r.p[FLAG_U] = 1'b1;
         end
         K_LDA: begin
            r.a = operand;
            r.p = nz_flags(r.p, operand);
         end
         K_LDX: begin
            r.x = operand;
            r.p = nz_flags(r.p, operand);
         end
         K_LDY: begin
            r.y = operand;
            r.p = nz_flags(r.p, operand);
         end
         K_LAX: begin
            r.a = operand;
            r.x = operand;
            r.p = nz_flags(r.p, operand);
         end
         K_ASL_A, K_LSR_A, K_ROL_A, K_ROR_A: begin
            t = shift_op(shift_kind_type'(kind - K_ASL_A), r.a, r.p);
            r.a = t.r;
            r.p = t.p;
         end
         K_ASL_M, K_LSR_M, K_ROL_M, K_ROR_M: begin
            t = shift_op(shift_kind_type'(kind - K_ASL_M), operand, r.p);
            r.p = t.p;
            m = t.r;
            wb = 1'b1;
         end
         K_INC_M: begin
            m = operand + 8'd1;
            r.p = nz_flags(r.p, m);
            wb = 1'b1;
         end
         K_DEC_M: begin
            m = operand - 8'd1;
            r.p = nz_flags(r.p, m);
            wb = 1'b1;
         end
         K_SLO: begin
            t = shift_op(SH_ASL, operand, r.p);
            m = t.r;
            wb = 1'b1;
            r.a = r.a | t.r;
            r.p = nz_flags(t.p, r.a);
         end
         K_RLA: begin
            t = shift_op(SH_ROL, operand, r.p);
            m = t.r;
            wb = 1'b1;
            r.a = r.a & t.r;
            r.p = nz_flags(t.p, r.a);
         end
         K_SRE: begin
            t = shift_op(SH_LSR, operand, r.p);
            m = t.r;
            wb = 1'b1;
            r.a = r.a ^ t.r;
            r.p = nz_flags(t.p, r.a);
         end
         K_RRA: begin
            t = shift_op(SH_ROR, operand, r.p);
            m = t.r;
            wb = 1'b1;
            t = add_op(r.a, m, t.p);
            r.a = t.r;
            r.p = t.p;
         end
         K_DCP: begin
            m = operand - 8'd1;
            wb = 1'b1;
            r.p = cmp_op(r.a, m, r.p);
         end
         K_ISB: begin
            m = operand + 8'd1;
            wb = 1'b1;
            t = add_op(r.a, ~m, r.p);
            r.a = t.r;
            r.p = t.p;
         end
         K_STA: begin
            m = r.a;
            wb = 1'b1;
         end
         K_STX: begin
            m = r.x;
            wb = 1'b1;
         end
         K_STY: begin
            m = r.y;
            wb = 1'b1;
         end
         K_SAX: begin
            m = r.a & r.x;
            wb = 1'b1;
         end
         K_TAX: begin
            r.x = r.a;
            r.p = nz_flags(r.p, r.a);
         end
         K_TAY: begin
            r.y = r.a;
            r.p = nz_flags(r.p, r.a);
         end
         K_TSX: begin
            r.x = r.sp;
            r.p = nz_flags(r.p, r.sp);
         end
         K_TXA: begin
            r.a = r.x;
            r.p = nz_flags(r.p, r.x);
         end
         K_TXS: r.sp = r.x;
         K_TYA: begin
            r.a = r.y;
            r.p = nz_flags(r.p, r.y);
         end
         K_INX: begin
            r.x = r.x + 8'd1;
            r.p = nz_flags(r.p, r.x);
         end
         K_INY: begin
            r.y = r.y + 8'd1;
            r.p = nz_flags(r.p, r.y);
         end
         K_DEX: begin
            r.x = r.x - 8'd1;
            r.p = nz_flags(r.p, r.x);
         end
         K_DEY: begin
            r.y = r.y - 8'd1;
            r.p = nz_flags(r.p, r.y);
         end
         K_CLC: r.p[FLAG_C] = 1'b0;
         K_SEC: r.p[FLAG_C] = 1'b1;
         K_CLI: r.p[FLAG_I] = 1'b0;
         K_SEI: r.p[FLAG_I] = 1'b1;
         K_CLV: r.p[FLAG_V] = 1'b0;
         K_CLD: r.p[FLAG_D] = 1'b0;
         K_SED: r.p[FLAG_D] = 1'b1;
         K_PHA, K_PHP: begin
            m = (kind == K_PHA) ? r.a : (r.p | PUSH_BITS);
            wb = 1'b1;
            stk = 1'b1;
            saddr = STACK_BASE | {1'b0, r.sp};
            r.sp = r.sp - 8'd1;
         end
         K_PLA: begin
            stk = 1'b1;
            r.sp = r.sp + 8'd1;
            saddr = STACK_BASE | {1'b0, r.sp};
            r.a = operand;
            r.p = nz_flags(r.p, operand);
         end
         K_PLP: begin
            stk = 1'b1;
            r.sp = r.sp + 8'd1;
            saddr = STACK_BASE | {1'b0, r.sp};
            r.p = (operand & ~PUSH_BITS) | UNUSED_BIT;
         end
         K_BCC: br = ~r.p[FLAG_C];
         K_BCS: br = r.p[FLAG_C];
         K_BEQ: br = r.p[FLAG_Z];
         K_BMI: br = r.p[FLAG_N];
         K_BNE: br = ~r.p[FLAG_Z];
         K_BPL: br = ~r.p[FLAG_N];
         K_BVC: br = ~r.p[FLAG_V];
         K_BVS: br = r.p[FLAG_V];
         K_NOP, K_NOP_ALT: begin
            br = 1'b0;
         end
         default: begin
            br = 1'b0;
         end
      endcase
      regs_next              = r;
      rsp_next.result_byte   = m;
      rsp_next.write_back    = wb;
      rsp_next.stack_access  = stk;
      rsp_next.stack_address = saddr;
      rsp_next.branch_taken  = br;
   end

endmodule

`default_nettype wire

[src/cpu_6502_execute_unit.sv]
// ----------------------------------------------------------------------------
// cpu_6502_execute_unit: execute datapath of a 6502-class CPU
// Holds A, X, Y, P and SP and runs one operation per accepted item.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    req_kind, req_operand
//   rsp      out        rsp_valid/stall    rsp_result_byte .. rsp_sp_out
//
// An accepted item updates the register file at the accepting edge and its
// result is shown from the output register, loaded at that same edge. One
// item is taken per cycle while the output is not stalled; the single execute
// pass between the register file and the output register sets that figure.
// Reset loads A, X, Y with zero, P with 0x24 and SP with 0xFD. req_stall is
// high only while a result waits on a stalled output.
`default_nettype none

module cpu_6502_execute_unit
   import c65x_pkg::*;
(
   input  var logic       clock,
   input  var logic       reset,
   input  var logic       req_valid,
   output var logic       req_stall,
   input  var logic [5:0] req_kind,
   input  var logic [7:0] req_operand,
   output var logic       rsp_valid,
   input  var logic       rsp_stall,
   output var logic [7:0] rsp_result_byte,
   output var logic       rsp_write_back,
   output var logic       rsp_stack_access,
   output var logic [8:0] rsp_stack_address,
   output var logic       rsp_branch_taken,
   output var logic [7:0] rsp_acc_out,
   output var logic [7:0] rsp_x_out,
   output var logic [7:0] rsp_y_out,
   output var logic [7:0] rsp_flags_out,
   output var logic [7:0] rsp_sp_out
);

   regs_type regs_ff;
   regs_type regs_in;
   rsp_type  rsp_in;
   rsp_type  rsp_ff;
   regs_type out_regs_ff;
   logic     rsp_valid_ff;
   logic     accept;

   c65x_alu u_alu (
      .kind      (kind_type'(req_kind)),
      .operand   (req_operand),
      .regs_cur  (regs_ff),
      .regs_next (regs_in),
      .rsp_next  (rsp_in)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.a  <= 8'h00;
         regs_ff.x  <= 8'h00;
         regs_ff.y  <= 8'h00;
         regs_ff.p  <= FLAGS_RESET;
         regs_ff.sp <= SP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            regs_ff <= regs_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff      <= rsp_in;
         out_regs_ff <= regs_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_byte   = rsp_ff.result_byte;
   assign rsp_write_back    = rsp_ff.write_back;
   assign rsp_stack_access  = rsp_ff.stack_access;
   assign rsp_stack_address = rsp_ff.stack_address;
   assign rsp_branch_taken  = rsp_ff.branch_taken;
   assign rsp_acc_out       = out_regs_ff.a;
   assign rsp_x_out         = out_regs_ff.x;
   assign rsp_y_out         = out_regs_ff.y;
   assign rsp_flags_out     = out_regs_ff.p;
   assign rsp_sp_out        = out_regs_ff.sp;

endmodule

`default_nettype wire

[src/c65x_checker.sv]
// ----------------------------------------------------------------------------
// c65x_checker: port-level checks of the execute unit
// Watches the handshakes and result fields over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module c65x_checker (
   input var logic       clock,
   input var logic       reset,
   input var logic       req_valid,
   input var logic       req_stall,
   input var logic       rsp_valid,
   input var logic       rsp_stall,
   input var logic [7:0] rsp_result_byte,
   input var logic       rsp_write_back,
   input var logic       rsp_stack_access,
   input var logic [8:0] rsp_stack_address,
   input var logic       rsp_branch_taken,
   input var logic [7:0] rsp_acc_out,
   input var logic [7:0] rsp_x_out,
   input var logic [7:0] rsp_y_out,
   input var logic [7:0] rsp_flags_out,
   input var logic [7:0] rsp_sp_out
);

   // A result that is held back keeps its valid and its whole payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_byte)
         && $stable(rsp_write_back) && $stable(rsp_stack_access)
         && $stable(rsp_stack_address) && $stable(rsp_branch_taken)
         && $stable(rsp_acc_out) && $stable(rsp_x_out) && $stable(rsp_y_out)
         && $stable(rsp_flags_out) && $stable(rsp_sp_out))
      else $error("stalled result item changed");

   // Every accepted item shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

   // The input side is held off only by a stalled, waiting result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // The unused flag stays set, and idle stack addresses point at the page base.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_flags_out[5] && (rsp_stack_access || rsp_stack_address == 9'h100)
         && (rsp_write_back || rsp_result_byte == 8'h00))
      else $error("inconsistent result fields");

   // No result is shown right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind cpu_6502_execute_unit c65x_checker u_checker (.*);

`default_nettype wire
